/* hdl/hcalu_pkg.sv */
`default_nettype none
package hcalu_pkg;

  localparam int WORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 24;

  // operation codes
  localparam logic [2:0] FN_ADD = 3'd0;
  localparam logic [2:0] FN_SUB = 3'd1;
  localparam logic [2:0] FN_NEG = 3'd2;
  localparam logic [2:0] FN_MUL = 3'd3;
  localparam logic [2:0] FN_SQR = 3'd4;
  localparam logic [2:0] FN_INV = 3'd5;

  // what the divider tail does with a request
  typedef struct packed {
    logic inv;   // result comes from the divider
    logic sing;  // determinant was zero
  } hcalu_kind_t;

endpackage
`default_nettype wire

/* hdl/hcalu_req_if.sv */
`default_nettype none
interface hcalu_req_if #(
  parameter int WORD_WIDTH = hcalu_pkg::WORD_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic [2:0]                   func;
  logic signed [WORD_WIDTH-1:0] a_x;
  logic signed [WORD_WIDTH-1:0] a_y;
  logic signed [WORD_WIDTH-1:0] a_z;
  logic signed [WORD_WIDTH-1:0] a_t;
  logic signed [WORD_WIDTH-1:0] b_x;
  logic signed [WORD_WIDTH-1:0] b_y;
  logic signed [WORD_WIDTH-1:0] b_z;
  logic signed [WORD_WIDTH-1:0] b_t;

  modport source (output valid, func, a_x, a_y, a_z, a_t, b_x, b_y, b_z, b_t,
                  input ready);
  modport sink (input valid, func, a_x, a_y, a_z, a_t, b_x, b_y, b_z, b_t,
                output ready);
endinterface
`default_nettype wire

/* hdl/hcalu_res_if.sv */
`default_nettype none
interface hcalu_res_if #(
  parameter int WORD_WIDTH = hcalu_pkg::WORD_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [WORD_WIDTH-1:0] r_x;
  logic signed [WORD_WIDTH-1:0] r_y;
  logic signed [WORD_WIDTH-1:0] r_z;
  logic signed [WORD_WIDTH-1:0] r_t;
  logic                         singular;
  logic                         saturated;

  modport source (output valid, r_x, r_y, r_z, r_t, singular, saturated,
                  input ready);
  modport sink (input valid, r_x, r_y, r_z, r_t, singular, saturated,
                output ready);
endinterface
`default_nettype wire

/* hdl/hcalu_div.sv */
`default_nettype none
// Restoring divider tail: overflow check, one quotient bit per stage,
// then sign fix-up, saturation and result selection.
module hcalu_div #(
  parameter int WORD_WIDTH = hcalu_pkg::WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = hcalu_pkg::FRAC_BITS_DEF,
  localparam int NW   = 3 * WORD_WIDTH + 3,
  localparam int NUMA = NW + 2 * FRAC_BITS + 2,
  localparam int NUMB = 4 * WORD_WIDTH + 3,
  localparam int NUMW = ((NUMA > NUMB) ? NUMA : NUMB) + 1,
  localparam int CWB  = 5 * WORD_WIDTH + 4,
  localparam int CW   = ((NUMW > CWB) ? NUMW : CWB) + 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [3:0][CW-1:0]              mag,
  input  logic [3:0]                      neg,
  input  logic [CW-1:0]                   den,
  input  hcalu_pkg::hcalu_kind_t          kind,
  input  logic [3:0][WORD_WIDTH-1:0]      side_r,
  input  logic                            side_sat,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [3:0][WORD_WIDTH-1:0]      r,
  output logic                            singular,
  output logic                            saturated
);
  import hcalu_pkg::*;

  localparam int W  = WORD_WIDTH;
  localparam int NS = W + 3;   // ovf stage, W+1 bit stages, output stage
  localparam int K  = W + 1;   // last bit stage
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  logic          v  [NS];
  logic          en [NS+1];

  logic [CW-1:0] rem    [K+1][4];
  logic [CW-1:0] rem_nx [K+1][4];
  logic [W:0]    q      [K+1][4];
  logic [W:0]    q_nx   [K+1][4];
  logic          ovf    [K+1][4];
  logic          ngv    [K+1][4];
  logic [CW-1:0] dv     [K+1];
  hcalu_kind_t   kd     [K+1];
  logic [3:0][W-1:0] sr [K+1];
  logic          ss     [K+1];

  // stall chain: a stage moves when empty or when its successor moves
  always_comb begin
    en[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = ~v[k] | en[k+1];
    end
  end
  assign in_ready  = en[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NS; k++) v[k] <= 1'b0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) v[k] <= (k == 0) ? in_valid : v[k-1];
      end
    end
  end

  // one quotient bit per stage
  always_comb begin
    logic [CW-1:0] sh;
    logic          ge;
    for (int l = 0; l < 4; l++) begin
      rem_nx[0][l] = mag[l];
      q_nx[0][l]   = '0;
    end
    for (int k = 1; k <= K; k++) begin
      for (int l = 0; l < 4; l++) begin
        sh = dv[k-1] << (K - k);
        ge = rem[k-1][l] >= sh;
        rem_nx[k][l] = ge ? rem[k-1][l] - sh : rem[k-1][l];
        q_nx[k][l]   = q[k-1][l] | ((W+1)'(ge) << (K - k));
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= K; k++) begin
      if (en[k]) begin
        for (int l = 0; l < 4; l++) begin
          rem[k][l] <= rem_nx[k][l];
          q[k][l]   <= q_nx[k][l];
          ovf[k][l] <= (k == 0) ? (mag[l] >= (den << (W + 1))) : ovf[k-1][l];
          ngv[k][l] <= (k == 0) ? neg[l] : ngv[k-1][l];
        end
        dv[k] <= (k == 0) ? den : dv[k-1];
        kd[k] <= (k == 0) ? kind : kd[k-1];
        sr[k] <= (k == 0) ? side_r : sr[k-1];
        ss[k] <= (k == 0) ? side_sat : ss[k-1];
      end
    end
  end

  // sign fix-up (floor for negative numerators) and clipping
  logic [3:0][W-1:0] dres;
  logic [3:0]        dsat;
  always_comb begin
    logic [W:0] q0;
    logic       rnz;
    for (int l = 0; l < 4; l++) begin
      q0  = q[K][l];
      rnz = |rem[K][l];
      if (ngv[K][l]) begin
        dsat[l] = ovf[K][l] | q0[W] | (q0[W-1] & ((|q0[W-2:0]) | rnz));
        dres[l] = dsat[l] ? WMIN : (rnz ? ~q0[W-1:0] : -q0[W-1:0]);
      end else begin
        dsat[l] = ovf[K][l] | q0[W] | q0[W-1];
        dres[l] = dsat[l] ? WMAX : q0[W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      if (kd[K].inv && kd[K].sing) begin
        r         <= '0;
        singular  <= 1'b1;
        saturated <= 1'b0;
      end else if (kd[K].inv) begin
        r         <= dres;
        singular  <= 1'b0;
        saturated <= |dsat;
      end else begin
        r         <= sr[K];
        singular  <= 1'b0;
        saturated <= ss[K];
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/hypercomplex_alu_top.sv */
`default_nettype none
// Commutative hypercomplex (x, y, z, t) arithmetic unit, Q(W-F).F fixed point.
// Channel op carries func and operands a, b; channel result carries r, the
// singular flag (invert with zero determinant) and the saturated flag.
// Both are valid/ready channels; a request moves when valid and ready are
// both high.
// Every request passes through the same stages, whatever the operation, so
// results leave in order. Throughput is one request per cycle unless result
// stalls: seven arithmetic stages (operand prep, products, sums, split products
// for the wide multiplies, numerator, scaling, magnitude) feed a divider with
// one restoring stage per quotient bit.
// Each stage holds its own valid bit; while result is stalled, empty stages
// still fill, so op stays ready until the whole pipe is full.
// Synchronous reset empties the pipe; no result is pending after it.
module hypercomplex_alu_top #(
  parameter int WORD_WIDTH = hcalu_pkg::WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = hcalu_pkg::FRAC_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  hcalu_req_if.sink   op,
  hcalu_res_if.source result
);
  import hcalu_pkg::*;

  localparam int W    = WORD_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int H    = W + 1;
  localparam int PW   = 2 * W + 2;
  localparam int NW   = 3 * W + 3;
  localparam int DW   = 4 * W + 2;
  localparam int NUMA = NW + 2 * F + 2;
  localparam int NUMB = 4 * W + 3;
  localparam int NUMW = ((NUMA > NUMB) ? NUMA : NUMB) + 1;
  localparam int CWB  = 5 * W + 4;
  localparam int CW   = ((NUMW > CWB) ? NUMW : CWB) + 1;
  localparam int NF   = 7;
  localparam logic [W-1:0]  WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [PW-1:0] RND = PW'(1) <<< (F - 1);

  function automatic logic [W:0] sat_word(input logic signed [PW-1:0] v);
    logic fits;
    fits = (&v[PW-1:W-1]) | ~(|v[PW-1:W-1]);
    if (fits) return {1'b0, v[W-1:0]};
    return {1'b1, v[PW-1] ? WMIN : WMAX};
  endfunction

  // stall chain over the front stages
  logic fv  [NF];
  logic fen [NF+1];
  logic div_ready;

  always_comb begin
    fen[NF] = div_ready;
    for (int k = NF - 1; k >= 0; k--) fen[k] = ~fv[k] | fen[k+1];
  end
  assign op.ready = fen[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NF; k++) fv[k] <= 1'b0;
    end else begin
      for (int k = 0; k < NF; k++) begin
        if (fen[k]) fv[k] <= (k == 0) ? op.valid : fv[k-1];
      end
    end
  end

  // operand capture, second operand chosen for square, sums for invert
  logic signed [W-1:0] ain [4];
  logic signed [W-1:0] bin [4];
  assign ain[0] = op.a_x;
  assign ain[1] = op.a_y;
  assign ain[2] = op.a_z;
  assign ain[3] = op.a_t;
  assign bin[0] = op.b_x;
  assign bin[1] = op.b_y;
  assign bin[2] = op.b_z;
  assign bin[3] = op.b_t;

  logic [2:0]          f1;
  logic signed [W-1:0] a1 [4];
  logic signed [W-1:0] b1 [4];
  logic signed [W:0]   s1 [4];   // x-t, y+z, x+t, y-z

  always_ff @(posedge clk) begin
    if (fen[0]) begin
      f1 <= op.func;
      for (int i = 0; i < 4; i++) begin
        a1[i] <= ain[i];
        b1[i] <= (op.func == FN_SQR) ? ain[i] : bin[i];
      end
      s1[0] <= H'(ain[0]) - H'(ain[3]);
      s1[1] <= H'(ain[1]) + H'(ain[2]);
      s1[2] <= H'(ain[0]) + H'(ain[3]);
      s1[3] <= H'(ain[1]) - H'(ain[2]);
    end
  end

  // products
  logic [2:0]            f2;
  logic signed [W-1:0]   a2 [4];
  logic signed [W-1:0]   b2 [4];
  logic signed [2*W-1:0] mp2 [4][4];
  logic signed [PW-1:0]  sq2 [4];
  logic signed [2*W-1:0] cc2 [4];
  logic signed [2*W-1:0] xt2;
  logic signed [2*W-1:0] yz2;

  always_ff @(posedge clk) begin
    if (fen[1]) begin
      f2 <= f1;
      for (int i = 0; i < 4; i++) begin
        a2[i]  <= a1[i];
        b2[i]  <= b1[i];
        sq2[i] <= s1[i] * s1[i];
        cc2[i] <= a1[i] * a1[i];
        for (int j = 0; j < 4; j++) mp2[i][j] <= a1[i] * b1[j];
      end
      xt2 <= a1[0] * a1[3];
      yz2 <= a1[1] * a1[2];
    end
  end

  // product sums with rounding, simple ops, determinant factors
  logic signed [PW-1:0] psum [4];
  logic [3:0][W-1:0]    side_nx;
  logic                 sside_nx;

  always_comb begin
    logic [W:0] sw;
    psum[0] = PW'(mp2[0][0]) - PW'(mp2[1][1]) - PW'(mp2[2][2]) + PW'(mp2[3][3]);
    psum[1] = PW'(mp2[1][0]) + PW'(mp2[0][1]) - PW'(mp2[3][2]) - PW'(mp2[2][3]);
    psum[2] = PW'(mp2[2][0]) - PW'(mp2[3][1]) + PW'(mp2[0][2]) - PW'(mp2[1][3]);
    psum[3] = PW'(mp2[3][0]) + PW'(mp2[2][1]) + PW'(mp2[1][2]) + PW'(mp2[0][3]);
    sside_nx = 1'b0;
    for (int i = 0; i < 4; i++) begin
      unique case (f2) inside
        FN_ADD:         sw = sat_word(PW'(a2[i]) + PW'(b2[i]));
        FN_SUB:         sw = sat_word(PW'(a2[i]) - PW'(b2[i]));
        FN_NEG:         sw = sat_word(-PW'(a2[i]));
        FN_MUL, FN_SQR: sw = sat_word((psum[i] + RND) >>> F);
        default:        sw = '0;
      endcase
      side_nx[i] = sw[W-1:0];
      sside_nx   = sside_nx | sw[W];
    end
  end

  logic                  inv3;
  logic [3:0][W-1:0]     side3;
  logic                  ssat3;
  logic [2*W:0]          d1_3;
  logic [2*W:0]          d2_3;
  logic [2*W:0]          mod3;
  logic signed [PW-1:0]  k2_3;
  logic signed [W-1:0]   a3 [4];

  always_ff @(posedge clk) begin
    if (fen[2]) begin
      inv3  <= (f2 == FN_INV);
      side3 <= side_nx;
      ssat3 <= sside_nx;
      d1_3  <= (2 * W + 1)'(((PW + 1)'(sq2[0]) + (PW + 1)'(sq2[1])));
      d2_3  <= (2 * W + 1)'(((PW + 1)'(sq2[2]) + (PW + 1)'(sq2[3])));
      mod3  <= (2 * W + 1)'(PW'(cc2[0]) + PW'(cc2[1]) + PW'(cc2[2]) + PW'(cc2[3]));
      k2_3  <= (PW'(xt2) - PW'(yz2)) <<< 1;
      for (int i = 0; i < 4; i++) a3[i] <= a2[i];
    end
  end

  // wide multiplies split into half-word partial products
  logic [W-1:0]        d1h, d2h, modh;
  logic [H-1:0]        d1l, d2l, modl, k2l;
  logic signed [W:0]   k2h;
  assign d1h  = d1_3[2*W:H];
  assign d1l  = d1_3[H-1:0];
  assign d2h  = d2_3[2*W:H];
  assign d2l  = d2_3[H-1:0];
  assign modh = mod3[2*W:H];
  assign modl = mod3[H-1:0];
  assign k2h  = k2_3[PW-1:H];
  assign k2l  = k2_3[H-1:0];

  logic                  inv4;
  logic [3:0][W-1:0]     side4;
  logic                  ssat4;
  logic [2*W-1:0]        dhh4;
  logic [2*W:0]          dhl4, dlh4;
  logic [2*W+1:0]        dll4;
  logic signed [2*W:0]   pah4 [4];
  logic signed [2*W:0]   pbh4 [4];
  logic signed [PW-1:0]  pal4 [4];
  logic signed [PW-1:0]  pbl4 [4];

  always_ff @(posedge clk) begin
    if (fen[3]) begin
      inv4  <= inv3;
      side4 <= side3;
      ssat4 <= ssat3;
      dhh4  <= d1h * d2h;
      dhl4  <= d1h * d2l;
      dlh4  <= d1l * d2h;
      dll4  <= d1l * d2l;
      for (int i = 0; i < 4; i++) begin
        pah4[i] <= a3[i] * $signed({1'b0, modh});
        pal4[i] <= a3[i] * $signed({1'b0, modl});
        pbh4[i] <= a3[3-i] * k2h;
        pbl4[i] <= a3[3-i] * $signed({1'b0, k2l});
      end
    end
  end

  // numerators and determinant
  logic signed [NW-1:0] n_nx [4];
  logic [DW-1:0]        det_nx;

  always_comb begin
    logic signed [NW-1:0] am;
    logic signed [NW-1:0] bk;
    for (int i = 0; i < 4; i++) begin
      am = (NW'(pah4[i]) <<< H) + NW'(pal4[i]);
      bk = (NW'(pbh4[i]) <<< H) + NW'(pbl4[i]);
      // x and t keep the sign of the modulus term, y and z flip it
      n_nx[i] = (i == 0 || i == 3) ? am - bk : -am - bk;
    end
    det_nx = (DW'(dhh4) << (2 * H)) + ((DW'(dhl4) + DW'(dlh4)) << H) + DW'(dll4);
  end

  logic                  inv5;
  logic [3:0][W-1:0]     side5;
  logic                  ssat5;
  logic signed [NW-1:0]  n5 [4];
  logic [DW-1:0]         det5;

  always_ff @(posedge clk) begin
    if (fen[4]) begin
      inv5  <= inv4;
      side5 <= side4;
      ssat5 <= ssat4;
      det5  <= det_nx;
      for (int i = 0; i < 4; i++) n5[i] <= n_nx[i];
    end
  end

  // scale numerator and add the half-divisor for round to nearest
  hcalu_kind_t           kind6;
  logic [3:0][W-1:0]     side6;
  logic                  ssat6;
  logic signed [NUMW-1:0] num6 [4];
  logic [DW:0]           den6;

  always_ff @(posedge clk) begin
    if (fen[5]) begin
      kind6.inv  <= inv5;
      kind6.sing <= (det5 == '0);
      side6      <= side5;
      ssat6      <= ssat5;
      den6       <= {det5, 1'b0};
      for (int i = 0; i < 4; i++) begin
        num6[i] <= (NUMW'(n5[i]) <<< (2 * F + 1)) + NUMW'($signed({1'b0, det5}));
      end
    end
  end

  // magnitude and sign for the unsigned divider
  hcalu_kind_t           kind7;
  logic [3:0][W-1:0]     side7;
  logic                  ssat7;
  logic [3:0][CW-1:0]    mag7;
  logic [3:0]            neg7;
  logic [CW-1:0]         den7;

  always_ff @(posedge clk) begin
    if (fen[6]) begin
      kind7 <= kind6;
      side7 <= side6;
      ssat7 <= ssat6;
      den7  <= CW'(den6);
      for (int i = 0; i < 4; i++) begin
        neg7[i] <= num6[i][NUMW-1];
        mag7[i] <= CW'($unsigned(num6[i][NUMW-1] ? -num6[i] : num6[i]));
      end
    end
  end

  logic [3:0][W-1:0] res_r;

  hcalu_div #(
    .WORD_WIDTH (WORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fv[NF-1]),
    .in_ready  (div_ready),
    .mag       (mag7),
    .neg       (neg7),
    .den       (den7),
    .kind      (kind7),
    .side_r    (side7),
    .side_sat  (ssat7),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .r         (res_r),
    .singular  (result.singular),
    .saturated (result.saturated)
  );

  assign result.r_x = res_r[0];
  assign result.r_y = res_r[1];
  assign result.r_z = res_r[2];
  assign result.r_t = res_r[3];

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
module tb;
  import hcalu_pkg::*;

  localparam int W          = WORD_WIDTH_DEF;
  localparam int F          = FRAC_BITS_DEF;
  localparam int STALL_LIM  = 4000;
  localparam int DRAIN_CYC  = 60;
  localparam int RAND_ITEMS = 400;

  typedef logic signed [255:0] wide_t;
  typedef logic signed [W-1:0] word_t;

  typedef struct {
    logic [2:0] func;
    word_t      a[4];
    word_t      b[4];
  } hc_req_t;

  typedef struct {
    word_t r[4];
    logic  singular;
    logic  saturated;
  } hc_res_t;

  // expected results and the arithmetic that produces them
  class hc_scoreboard;
    hc_res_t pending[$];
    int      errors;

    function new();
      errors = 0;
    endfunction

    function wide_t pr(wide_t p, wide_t q);
      return p * q;
    endfunction

    // clip to the word range, noting any clipping
    function word_t clip(wide_t v, inout bit s);
      wide_t hi, lo;
      hi = (wide_t'(1) <<< (W - 1)) - 1;
      lo = -(wide_t'(1) <<< (W - 1));
      if (v > hi) begin
        s = 1;
        return word_t'(hi);
      end
      if (v < lo) begin
        s = 1;
        return word_t'(lo);
      end
      return word_t'(v);
    endfunction

    // round half up from 2F fraction bits
    function word_t round_prod(wide_t p, inout bit s);
      return clip((p + (wide_t'(1) <<< (F - 1))) >>> F, s);
    endfunction

    // nearest of n/d, ties up; d is positive
    function word_t round_quot(wide_t n, wide_t d, inout bit s);
      wide_t num, den, q;
      num = (n <<< (2 * F + 1)) + d;
      den = d <<< 1;
      q   = num / den;
      if (num < 0 && q * den != num) q = q - 1;
      return clip(q, s);
    endfunction

    function hc_res_t predict_hc(hc_req_t rq);
      hc_res_t o;
      wide_t   a[4], b[4], d1, d2, det, md, k2;
      bit      s;
      s = 0;
      for (int i = 0; i < 4; i++) begin
        a[i] = rq.a[i];
        b[i] = rq.b[i];
        o.r[i] = '0;
      end
      o.singular = 0;
      if (rq.func == FN_SQR) b = a;
      case (rq.func)
        FN_ADD: for (int i = 0; i < 4; i++) o.r[i] = clip(a[i] + b[i], s);
        FN_SUB: for (int i = 0; i < 4; i++) o.r[i] = clip(a[i] - b[i], s);
        FN_NEG: for (int i = 0; i < 4; i++) o.r[i] = clip(-a[i], s);
        FN_MUL, FN_SQR: begin
          o.r[0] = round_prod(pr(a[0], b[0]) - pr(a[1], b[1]) - pr(a[2], b[2])
                              + pr(a[3], b[3]), s);
          o.r[1] = round_prod(pr(a[1], b[0]) + pr(a[0], b[1]) - pr(a[3], b[2])
                              - pr(a[2], b[3]), s);
          o.r[2] = round_prod(pr(a[2], b[0]) - pr(a[3], b[1]) + pr(a[0], b[2])
                              - pr(a[1], b[3]), s);
          o.r[3] = round_prod(pr(a[3], b[0]) + pr(a[2], b[1]) + pr(a[1], b[2])
                              + pr(a[0], b[3]), s);
        end
        FN_INV: begin
          d1  = pr(a[0] - a[3], a[0] - a[3]) + pr(a[1] + a[2], a[1] + a[2]);
          d2  = pr(a[0] + a[3], a[0] + a[3]) + pr(a[1] - a[2], a[1] - a[2]);
          det = d1 * d2;
          if (det == 0) begin
            o.singular = 1;
          end else begin
            md = pr(a[0], a[0]) + pr(a[1], a[1]) + pr(a[2], a[2]) + pr(a[3], a[3]);
            k2 = (pr(a[0], a[3]) - pr(a[1], a[2])) <<< 1;
            o.r[0] = round_quot(a[0] * md - a[3] * k2, det, s);
            o.r[1] = round_quot(-(a[1] * md) - a[2] * k2, det, s);
            o.r[2] = round_quot(-(a[2] * md) - a[1] * k2, det, s);
            o.r[3] = round_quot(a[3] * md - a[0] * k2, det, s);
          end
        end
        default: ;
      endcase
      o.saturated = s;
      return o;
    endfunction

    function void note_request(hc_req_t rq);
      pending.push_back(predict_hc(rq));
    endfunction

    function void check_result(hc_res_t got);
      hc_res_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result r=%h %h %h %h", $time,
                 got.r[0], got.r[1], got.r[2], got.r[3]);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      for (int i = 0; i < 4; i++)
        if (got.r[i] !== exp_r.r[i]) begin
          $display("%0t: r[%0d] expected %h actual %h", $time, i, exp_r.r[i], got.r[i]);
          errors++;
        end
      if (got.singular !== exp_r.singular) begin
        $display("%0t: singular expected %b actual %b", $time,
                 exp_r.singular, got.singular);
        errors++;
      end
      if (got.saturated !== exp_r.saturated) begin
        $display("%0t: saturated expected %b actual %b", $time,
                 exp_r.saturated, got.saturated);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   send_idle;
  int   recv_idle;
  int   quiet_cyc;
  hc_scoreboard sb;

  hcalu_req_if op_if ();
  hcalu_res_if res_if ();

  hypercomplex_alu_top u_top (
    .clk    (clk),
    .rst    (rst),
    .op     (op_if),
    .result (res_if)
  );

  initial clk = 0;
  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    res_if.ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // monitor both channels and watch for a hang
  always @(posedge clk) begin
    hc_req_t rq;
    hc_res_t rs;
    if (!rst && op_if.valid && op_if.ready) begin
      rq.func = op_if.func;
      rq.a = '{op_if.a_x, op_if.a_y, op_if.a_z, op_if.a_t};
      rq.b = '{op_if.b_x, op_if.b_y, op_if.b_z, op_if.b_t};
      sb.note_request(rq);
    end
    if (!rst && res_if.valid && res_if.ready) begin
      rs.r = '{res_if.r_x, res_if.r_y, res_if.r_z, res_if.r_t};
      rs.singular  = res_if.singular;
      rs.saturated = res_if.saturated;
      sb.check_result(rs);
    end
    if ((op_if.valid && op_if.ready) || (res_if.valid && res_if.ready) || rst)
      quiet_cyc <= 0;
    else
      quiet_cyc <= quiet_cyc + 1;
    if (quiet_cyc >= STALL_LIM) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // drive one request, entered at a falling edge, left at a falling edge
  task automatic push(logic [2:0] f, word_t ax, word_t ay, word_t az, word_t at,
                      word_t bx, word_t by, word_t bz, word_t bt);
    while ($urandom_range(0, 99) < send_idle) begin
      op_if.valid <= 0;
      @(negedge clk);
    end
    op_if.valid <= 1;
    op_if.func  <= f;
    op_if.a_x <= ax; op_if.a_y <= ay; op_if.a_z <= az; op_if.a_t <= at;
    op_if.b_x <= bx; op_if.b_y <= by; op_if.b_z <= bz; op_if.b_t <= bt;
    @(posedge clk);
    while (!op_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    op_if.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // word mix: full range, fractal-sized, tiny, extremes and zero
  function automatic word_t rnd_word();
    case ($urandom_range(0, 7))
      0, 1:    return word_t'($urandom);
      2, 3, 4: return word_t'($urandom_range(0, 32'h0400_0000)) - word_t'(32'h0200_0000);
      5:       return word_t'($urandom_range(0, 64)) - 32;
      6:       return $urandom_range(0, 1) ? word_t'(32'h7fff_ffff) : word_t'(32'h8000_0000);
      default: return '0;
    endcase
  endfunction

  function automatic logic [2:0] rnd_func();
    return ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
  endfunction

  task automatic rand_phase(int n);
    word_t v[8];
    logic [2:0] f;
    for (int k = 0; k < n; k++) begin
      foreach (v[i]) v[i] = rnd_word();
      f = rnd_func();
      // occasionally force a singular invert: x = t, y = -z
      if (f == FN_INV && $urandom_range(0, 9) == 0) begin
        v[3] = v[0];
        v[2] = -v[1];
      end
      push(f, v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
    end
  endtask

  localparam word_t MAXW = 32'h7fff_ffff;
  localparam word_t MINW = 32'h8000_0000;
  localparam word_t ONE  = 32'h0100_0000;
  localparam word_t HALF = 32'h0080_0000;

  initial begin
    sb = new();
    quiet_cyc = 0;
    send_idle = 13;
    recv_idle = 55;
    rst = 1;
    res_if.ready = 0;
    op_if.valid = 0;
    op_if.func  = FN_ADD;
    op_if.a_x = '0; op_if.a_y = '0; op_if.a_z = '0; op_if.a_t = '0;
    op_if.b_x = '0; op_if.b_y = '0; op_if.b_z = '0; op_if.b_t = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: extremes, every code, singular and clipping cases
    push(FN_ADD, MAXW, MINW, '0, ONE, MAXW, MINW, '0, -ONE);
    push(FN_SUB, MAXW, MINW, '0, MINW, MINW, MAXW, MINW, MINW);
    push(FN_NEG, MINW, MAXW, '0, -1, '0, '0, '0, '0);
    push(FN_MUL, ONE, '0, '0, '0, HALF, -HALF, 3, MINW);
    push(FN_MUL, MAXW, MAXW, MINW, MINW, MAXW, MINW, MAXW, MINW);
    push(FN_MUL, 1, -1, 1, -1, HALF, HALF, HALF, HALF);
    push(FN_SQR, MINW, MINW, MINW, MINW, '0, '0, '0, '0);
    push(FN_SQR, HALF, -HALF, ONE, 5, MAXW, MAXW, MAXW, MAXW);
    push(FN_INV, ONE, '0, '0, '0, '0, '0, '0, '0);
    push(FN_INV, '0, '0, '0, '0, MAXW, MAXW, MAXW, MAXW);
    push(FN_INV, ONE, HALF, -HALF, ONE, '0, '0, '0, '0);
    push(FN_INV, MAXW, MAXW, MINW, MINW, '0, '0, '0, '0);
    push(FN_INV, 1, '0, '0, '0, '0, '0, '0, '0);
    push(FN_INV, MAXW, '0, ONE, HALF, '0, '0, '0, '0);
    push(FN_INV, -ONE, 3*HALF, ONE, -HALF, '0, '0, '0, '0);
    push(3'd6, MAXW, MINW, ONE, -1, MAXW, MINW, ONE, -1);
    push(3'd7, -1, -1, -1, -1, -1, -1, -1, -1);
    drain();

    rand_phase(RAND_ITEMS);
    drain();
    send_idle = 55;
    recv_idle = 13;
    rand_phase(RAND_ITEMS);
    drain();
    send_idle = 0;
    recv_idle = 0;
    rand_phase(RAND_ITEMS);

    drain();
    repeat (DRAIN_CYC) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

/* filelist.f */
hdl/hcalu_pkg.sv
hdl/hcalu_req_if.sv
hdl/hcalu_res_if.sv
hdl/hcalu_div.sv
hdl/hypercomplex_alu_top.sv
tb/sv/tb.sv
